### rtl/pmmp_pkg.sv
// Shared types and constants for the pointer motion and mode processor.
`default_nettype none

package pmmp_pkg;

    // Item operation codes
    typedef enum logic [2:0] {
        OP_MOTION       = 3'd0,
        OP_STEP_DEFAULT = 3'd1,
        OP_STEP_SNIPE   = 3'd2,
        OP_SET_SNIPE    = 3'd3,
        OP_SET_DRAG     = 3'd4,
        OP_TOGGLE_SNIPE = 3'd5,
        OP_TOGGLE_DRAG  = 3'd6
    } op_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACCEL_ENABLE = 2'd0,
        CFG_REVERSE_X    = 2'd1,
        CFG_REVERSE_Y    = 2'd2,
        CFG_THRESHOLD    = 2'd3
    } cfg_idx_t;

    // Acceleration divisor for d +/- d*d/ACCEL_DIVISOR
    localparam int ACCEL_DIVISOR = 24;

    // Reciprocal of the divisor: (sq * ACCEL_RECIP) >> ACCEL_RECIP_SHIFT gives
    // sq / ACCEL_DIVISOR exactly for squares up to 2**14 and divisors up to 255
    localparam int ACCEL_RECIP_SHIFT = 22;
    localparam int ACCEL_RECIP       = (2**ACCEL_RECIP_SHIFT + ACCEL_DIVISOR - 1)
                                       / ACCEL_DIVISOR;

    // CPI table constants
    localparam int CPI_W          = 12;
    localparam int DRAG_CPI       = 400;
    localparam int SNIPE_CPI_BASE = 200;
    localparam int SNIPE_CPI_STEP = 100;
    localparam int DEF_CPI_BASE   = 400;
    localparam int DEF_CPI_STEP   = 200;

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 6'd1;

endpackage

`default_nettype wire

### rtl/pointer_motion_mode_processor_core.sv
// Pointer motion and mode processor: top level with input and result registers.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: either a
//   motion report (operation = motion) or a mode event that steps a DPI index
//   or sets/toggles the sniping or drag-scroll flag.
//   Result channel (out_valid/out_ready) returns exactly one result per item,
//   in order: processed motion, scroll values, sensor CPI and current flags.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four
//   registers; it is always ready and should only be used while idle.
// Pipeline: an accepted item passes through two register stages, the input
//   register and then the result register, which it enters once that is free.
// Throughput: one item per cycle while out_ready is high; all per-item work
//   is a single pass of logic between the two registers, the 8x8 square and
//   the reciprocal multiply in the acceleration path being the longest piece.
// Reset: flags, DPI indexes and scroll accumulators clear to zero, config
//   registers take their reset values (threshold = 1), both stages go empty.
// Stall: while out_ready is low the result register holds; one more item
//   can still sit in the input register, after which in_ready drops.
`default_nettype none

module pointer_motion_mode_processor_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [2:0]                            operation,
    input  wire logic signed [7:0]                     motion_x,
    input  wire logic signed [7:0]                     motion_y,
    input  wire logic signed [7:0]                     wheel_h,
    input  wire logic signed [7:0]                     wheel_v,
    input  wire logic                                  forward,
    input  wire logic                                  enable,
    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [7:0]                          out_x,
    output logic signed [7:0]                          out_y,
    output logic signed [7:0]                          out_h,
    output logic signed [7:0]                          out_v,
    output logic [pmmp_pkg::CPI_W-1:0]                 sensor_cpi,
    output logic                                       dragscroll_active,
    output logic                                       sniping_active,
    // configuration channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [pmmp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [pmmp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int CW = pmmp_pkg::CPI_W;

    // Saturating quadratic acceleration; the quotient uses a reciprocal multiply
    function automatic logic signed [7:0] accel(input logic signed [7:0] d);
        logic signed [15:0] prod;
        logic        [14:0] sq;
        logic        [37:0] qprod;
        logic        [14:0] q;
        logic signed [16:0] ds;
        logic signed [16:0] qs;
        logic signed [16:0] r;
        logic signed [7:0]  res;
        prod  = d * d;
        sq    = prod[14:0];
        qprod = 38'(sq) * 38'(pmmp_pkg::ACCEL_RECIP);
        q     = qprod[pmmp_pkg::ACCEL_RECIP_SHIFT +: 15];
        ds    = 17'(d);
        qs    = $signed({2'b00, q});
        r     = (d > 8'sd0) ? ds + qs : ds - qs;
        if (r < -17'sd127)
            res = -8'sd127;
        else if (r > 17'sd127)
            res = 8'sd127;
        else
            res = r[7:0];
        return res;
    endfunction

    // Configuration registers
    logic                                accel_enable_reg;
    logic                                reverse_x_reg;
    logic                                reverse_y_reg;
    logic [pmmp_pkg::CFG_DATA_W-1:0]     threshold_reg;

    // Input stage
    logic                                in_valid_reg;
    pmmp_pkg::op_t                       op_reg;
    logic signed [7:0]                   mx_reg;
    logic signed [7:0]                   my_reg;
    logic signed [7:0]                   wh_reg;
    logic signed [7:0]                   wv_reg;
    logic                                fwd_reg;
    logic                                en_reg;

    // Block state
    logic [3:0]                          def_idx_reg;
    logic [1:0]                          snipe_idx_reg;
    logic                                drag_reg;
    logic                                snipe_reg;
    logic signed [8:0]                   acc_x_reg;
    logic signed [8:0]                   acc_y_reg;

    logic [3:0]                          def_idx_next;
    logic [1:0]                          snipe_idx_next;
    logic                                drag_next;
    logic                                snipe_next;
    logic signed [8:0]                   acc_x_next;
    logic signed [8:0]                   acc_y_next;

    // Result stage
    logic                                out_valid_reg;
    logic signed [7:0]                   ox_reg;
    logic signed [7:0]                   oy_reg;
    logic signed [7:0]                   oh_reg;
    logic signed [7:0]                   ov_reg;
    logic [CW-1:0]                       cpi_reg;
    logic                                drag_out_reg;
    logic                                snipe_out_reg;

    logic signed [7:0]                   ox_next;
    logic signed [7:0]                   oy_next;
    logic signed [7:0]                   oh_next;
    logic signed [7:0]                   ov_next;
    logic [CW-1:0]                       cpi_next;

    // Scroll accumulation terms
    logic signed [8:0]                   sum_x;
    logic signed [8:0]                   sum_y;
    logic        [9:0]                   mag_x;
    logic        [9:0]                   mag_y;
    logic                                cross_x;
    logic                                cross_y;

    logic                                advance;
    logic                                in_fire;
    logic                                proc;

    // Handshake control
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign proc      = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_enable_reg <= 1'b0;
            reverse_x_reg    <= 1'b0;
            reverse_y_reg    <= 1'b0;
            threshold_reg    <= pmmp_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pmmp_pkg::cfg_idx_t'(cfg_index))
                pmmp_pkg::CFG_ACCEL_ENABLE: accel_enable_reg <= cfg_data[0];
                pmmp_pkg::CFG_REVERSE_X:    reverse_x_reg    <= cfg_data[0];
                pmmp_pkg::CFG_REVERSE_Y:    reverse_y_reg    <= cfg_data[0];
                pmmp_pkg::CFG_THRESHOLD:    threshold_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_fire)
            in_valid_reg <= 1'b1;
        else if (proc)
            in_valid_reg <= 1'b0;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= pmmp_pkg::op_t'(operation);
            mx_reg  <= motion_x;
            my_reg  <= motion_y;
            wh_reg  <= wheel_h;
            wv_reg  <= wheel_v;
            fwd_reg <= forward;
            en_reg  <= enable;
        end
    end

    // Drag-scroll accumulation and threshold test
    always_comb
    begin
        sum_x   = reverse_x_reg ? acc_x_reg - {mx_reg[7], mx_reg}
                                : acc_x_reg + {mx_reg[7], mx_reg};
        sum_y   = reverse_y_reg ? acc_y_reg - {my_reg[7], my_reg}
                                : acc_y_reg + {my_reg[7], my_reg};
        mag_x   = sum_x[8] ? 10'd0 - {1'b1, sum_x} : {1'b0, sum_x};
        mag_y   = sum_y[8] ? 10'd0 - {1'b1, sum_y} : {1'b0, sum_y};
        cross_x = mag_x > {4'd0, threshold_reg};
        cross_y = mag_y > {4'd0, threshold_reg};
    end

    // Per-item state update and result values
    always_comb
    begin
        def_idx_next   = def_idx_reg;
        snipe_idx_next = snipe_idx_reg;
        drag_next      = drag_reg;
        snipe_next     = snipe_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        ox_next        = 8'sd0;
        oy_next        = 8'sd0;
        oh_next        = 8'sd0;
        ov_next        = 8'sd0;
        unique case (op_reg)
            pmmp_pkg::OP_MOTION:
            begin
                if (drag_reg)
                begin
                    acc_x_next = cross_x ? 9'sd0 : sum_x;
                    acc_y_next = cross_y ? 9'sd0 : sum_y;
                    oh_next    = cross_x ? (sum_x[8] ? -8'sd1 : 8'sd1) : wh_reg;
                    ov_next    = cross_y ? (sum_y[8] ? -8'sd1 : 8'sd1) : wv_reg;
                end
                else
                begin
                    oh_next = wh_reg;
                    ov_next = wv_reg;
                    if (!snipe_reg && accel_enable_reg)
                    begin
                        ox_next = accel(mx_reg);
                        oy_next = accel(my_reg);
                    end
                    else
                    begin
                        ox_next = mx_reg;
                        oy_next = my_reg;
                    end
                end
            end
            pmmp_pkg::OP_STEP_DEFAULT:
                def_idx_next = fwd_reg ? def_idx_reg + 4'd1 : def_idx_reg - 4'd1;
            pmmp_pkg::OP_STEP_SNIPE:
                snipe_idx_next = fwd_reg ? snipe_idx_reg + 2'd1 : snipe_idx_reg - 2'd1;
            pmmp_pkg::OP_SET_SNIPE:    snipe_next = en_reg;
            pmmp_pkg::OP_SET_DRAG:     drag_next  = en_reg;
            pmmp_pkg::OP_TOGGLE_SNIPE: snipe_next = !snipe_reg;
            pmmp_pkg::OP_TOGGLE_DRAG:  drag_next  = !drag_reg;
            default:                   ;
        endcase

        // CPI from the mode after this item
        if (drag_next)
            cpi_next = CW'(pmmp_pkg::DRAG_CPI);
        else if (snipe_next)
            cpi_next = CW'(pmmp_pkg::SNIPE_CPI_BASE)
                     + CW'(snipe_idx_next) * CW'(pmmp_pkg::SNIPE_CPI_STEP);
        else
            cpi_next = CW'(pmmp_pkg::DEF_CPI_BASE)
                     + CW'(def_idx_next) * CW'(pmmp_pkg::DEF_CPI_STEP);
    end

    // Block state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_idx_reg   <= '0;
            snipe_idx_reg <= '0;
            drag_reg      <= 1'b0;
            snipe_reg     <= 1'b0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
        end
        else if (proc)
        begin
            def_idx_reg   <= def_idx_next;
            snipe_idx_reg <= snipe_idx_next;
            drag_reg      <= drag_next;
            snipe_reg     <= snipe_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
        end
    end

    // Result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            oh_reg        <= oh_next;
            ov_reg        <= ov_next;
            cpi_reg       <= cpi_next;
            drag_out_reg  <= drag_next;
            snipe_out_reg <= snipe_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_x             = ox_reg;
    assign out_y             = oy_reg;
    assign out_h             = oh_reg;
    assign out_v             = ov_reg;
    assign sensor_cpi        = cpi_reg;
    assign dragscroll_active = drag_out_reg;
    assign sniping_active    = snipe_out_reg;

endmodule

`default_nettype wire

### rtl/pmmp_checker.sv
// Port-level assertion checker for the pointer motion and mode processor.
`default_nettype none

module pmmp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [7:0]             out_x,
    input wire logic signed [7:0]             out_y,
    input wire logic [pmmp_pkg::CPI_W-1:0]    sensor_cpi,
    input wire logic                          dragscroll_active,
    input wire logic                          sniping_active
);

    // A stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(sensor_cpi) && $stable(dragscroll_active))
        else $error("result changed while stalled");

    // Drag-scroll always reports its fixed CPI
    a_drag_cpi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dragscroll_active |-> sensor_cpi == pmmp_pkg::CPI_W'(pmmp_pkg::DRAG_CPI))
        else $error("wrong CPI in drag-scroll");

    // Drag-scroll consumes all pointer motion
    a_drag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dragscroll_active |-> out_x == 8'sd0 && out_y == 8'sd0)
        else $error("motion leaked in drag-scroll");

    // Sniping CPI stays within its four-step range
    a_snipe_cpi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sniping_active && !dragscroll_active |->
            sensor_cpi >= pmmp_pkg::CPI_W'(pmmp_pkg::SNIPE_CPI_BASE)
            && sensor_cpi <= pmmp_pkg::CPI_W'(pmmp_pkg::SNIPE_CPI_BASE
                                              + 3 * pmmp_pkg::SNIPE_CPI_STEP))
        else $error("sniping CPI out of range");

    // Normal mode CPI never drops below the default base
    a_def_cpi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sniping_active && !dragscroll_active |->
            sensor_cpi >= pmmp_pkg::CPI_W'(pmmp_pkg::DEF_CPI_BASE))
        else $error("default CPI out of range");

endmodule

bind pointer_motion_mode_processor_core pmmp_checker u_pmmp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x             (out_x),
    .out_y             (out_y),
    .sensor_cpi        (sensor_cpi),
    .dragscroll_active (dragscroll_active),
    .sniping_active    (sniping_active)
);

`default_nettype wire
